// ===== rtl/core/ln_pkg.sv =====
package ln_pkg;

    localparam int DATA_W        = 16;
    localparam int DIVIDEND_W    = 57;
    localparam int DIVISOR_W     = 34;
    localparam int ROOT_W        = 29;

    localparam logic [1:0] CMD_GAIN   = 2'd0;
    localparam logic [1:0] CMD_OFFSET = 2'd1;
    localparam logic [1:0] CMD_SAMPLE = 2'd2;

    localparam logic [1:0] REG_DEPTH  = 2'd0;
    localparam logic [1:0] REG_EPS    = 2'd1;

    localparam logic signed [DATA_W-1:0] GAIN_ONE    = 16'sd256;
    localparam logic signed [DATA_W-1:0] OFFSET_ZERO = 16'sd0;
    localparam logic [ROOT_W-1:0]        INV_SAT     = 29'h1000_0000;
    localparam logic [6:0]               DEPTH_RESET = 7'd64;
    localparam logic [15:0]              EPS_RESET   = 16'd1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SUM,
        ST_MEAN_GO,
        ST_MEAN_WAIT,
        ST_SQ,
        ST_VAR_GO,
        ST_VAR_WAIT,
        ST_RECIP_GO,
        ST_RECIP_WAIT,
        ST_SQRT_GO,
        ST_SQRT_WAIT,
        ST_EMIT_RD,
        ST_EMIT_MUL1,
        ST_EMIT_MUL2,
        ST_EMIT_OUT
    } state_t;

endpackage

// ===== rtl/core/ln_divider.sv =====
module ln_divider (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             go,
    input  logic [ln_pkg::DIVIDEND_W-1:0]    dividend,
    input  logic [ln_pkg::DIVISOR_W-1:0]     divisor,
    output logic                             done,
    output logic [ln_pkg::DIVIDEND_W-1:0]    quotient
);

    localparam int CNT_W = $clog2(ln_pkg::DIVIDEND_W + 1);

    logic [CNT_W-1:0]                  cnt_reg;
    logic                              done_reg;
    logic [ln_pkg::DIVIDEND_W-1:0]     quo_reg;
    logic [ln_pkg::DIVISOR_W-1:0]      rem_reg;
    logic [ln_pkg::DIVISOR_W-1:0]      dsr_reg;
    logic [ln_pkg::DIVISOR_W:0]        shifted;
    logic [ln_pkg::DIVISOR_W:0]        diff;
    logic                              ge;

    // one restoring step: bring down the next dividend bit
    assign shifted = {rem_reg, quo_reg[ln_pkg::DIVIDEND_W-1]};
    assign diff    = shifted - {1'b0, dsr_reg};
    assign ge      = (shifted >= {1'b0, dsr_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (go)
            begin
                cnt_reg <= CNT_W'(ln_pkg::DIVIDEND_W);
            end
            else if (cnt_reg != '0)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end
        else if (cnt_reg != '0)
        begin
            quo_reg <= {quo_reg[ln_pkg::DIVIDEND_W-2:0], ge};
            rem_reg <= ge ? diff[ln_pkg::DIVISOR_W-1:0] : shifted[ln_pkg::DIVISOR_W-1:0];
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== rtl/core/ln_isqrt.sv =====
module ln_isqrt (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          go,
    input  logic [ln_pkg::DIVIDEND_W-1:0] radicand,
    output logic                          done,
    output logic [ln_pkg::ROOT_W-1:0]     root
);

    localparam int RAD_W = 2 * ln_pkg::ROOT_W;
    localparam int REM_W = ln_pkg::ROOT_W + 2;
    localparam int CNT_W = $clog2(ln_pkg::ROOT_W + 1);

    logic [CNT_W-1:0]              cnt_reg;
    logic                          done_reg;
    logic [RAD_W-1:0]              rad_reg;
    logic [REM_W-1:0]              rem_reg;
    logic [ln_pkg::ROOT_W-1:0]     root_reg;
    logic [REM_W+1:0]              rem_s;
    logic [REM_W+1:0]              trial;
    logic                          ge;

    // one root bit per step, two radicand bits brought down
    assign rem_s = {rem_reg, rad_reg[RAD_W-1 -: 2]};
    assign trial = {1'b0, root_reg, 2'b01};
    assign ge    = (rem_s >= trial);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (go)
            begin
                cnt_reg <= CNT_W'(ln_pkg::ROOT_W);
            end
            else if (cnt_reg != '0)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            rad_reg  <= RAD_W'(radicand);
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (cnt_reg != '0)
        begin
            rad_reg  <= {rad_reg[RAD_W-3:0], 2'b00};
            rem_reg  <= ge ? REM_W'(rem_s - trial) : REM_W'(rem_s);
            root_reg <= {root_reg[ln_pkg::ROOT_W-2:0], ge};
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

// ===== rtl/core/layer_normalization_unit.sv =====
// Loads and non-final samples are taken while the block stays idle; a vector of
// n elements then holds busy through sum, divide, square sum, two divides on the
// shared divider, square root, then read, two multiplies and output per result.
// Throughput: one vector at a time; the receiver cannot stall the results. Reset
// restores gains to 1.0, offsets to 0.0, registers to their defaults and clears
// the element count; buffer data is not kept.
module layer_normalization_unit #(
    parameter int MAX_CHANNELS = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         command,
    input  logic [5:0]         channel_index,
    input  logic signed [15:0] data_value,
    input  logic               vector_end,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    output logic               result_valid,
    output logic signed [15:0] normalized_value,
    output logic               result_last
);

    localparam int ADDR_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int CNT_W  = $clog2(MAX_CHANNELS + 1);

    ln_pkg::state_t state_reg, state_next;

    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  n_reg, n_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic              pend_a_reg, pend_a_next;
    logic              pend_b_reg, pend_b_next;
    logic              out_valid_reg, out_valid_next;
    logic              out_last_reg;
    logic signed [15:0] out_value_reg;

    logic [6:0]        depth_reg;
    logic [15:0]       eps_reg;

    logic signed [15:0] buf_mem [MAX_CHANNELS];
    logic signed [15:0] gain_mem [MAX_CHANNELS];
    logic signed [15:0] offset_mem [MAX_CHANNELS];
    logic [MAX_CHANNELS-1:0] gain_vld_reg;
    logic [MAX_CHANNELS-1:0] offset_vld_reg;

    logic signed [15:0] buf_q_reg;
    logic signed [15:0] gain_q_reg;
    logic signed [15:0] offset_q_reg;
    logic               gain_ok_reg;
    logic               offset_ok_reg;

    logic signed [21:0] sum_reg;
    logic [37:0]        sq_reg;
    logic [31:0]        sqp_reg;
    logic signed [16:0] mean_reg;
    logic [32:0]        var_reg;
    logic [ln_pkg::ROOT_W-1:0] inv_reg;
    logic signed [46:0] p1_reg;
    logic signed [62:0] p_reg;

    logic               accept;
    logic               is_sample;
    logic               trigger;
    logic [CNT_W-1:0]   eff;
    logic [CNT_W-1:0]   count_inc;
    logic [ADDR_W-1:0]  rd_addr;
    logic               load_ok;

    logic               div_go;
    logic               div_done;
    logic [ln_pkg::DIVIDEND_W-1:0] div_dividend;
    logic [ln_pkg::DIVISOR_W-1:0]  div_divisor;
    logic [ln_pkg::DIVIDEND_W-1:0] div_quotient;
    logic               sqrt_go;
    logic               sqrt_done;
    logic [ln_pkg::ROOT_W-1:0]     sqrt_root;

    logic               sum_neg;
    logic [21:0]        sum_mag;
    logic [ln_pkg::DIVISOR_W-1:0]  v_sum;
    logic signed [16:0] d;
    logic signed [33:0] d_sq;
    logic signed [29:0] inv_s;
    logic signed [46:0] p1_full;
    logic signed [15:0] gain_eff;
    logic signed [15:0] offset_eff;
    logic signed [62:0] p_full;
    logic               p_neg;
    logic [62:0]        p_mag;
    logic [62:0]        p_rnd;
    logic signed [27:0] r_s;
    logic signed [29:0] y_full;
    logic signed [15:0] y_sat;

    assign accept    = start && !busy;
    assign is_sample = (command == ln_pkg::CMD_SAMPLE);
    assign load_ok   = ({26'd0, channel_index} < 32'(MAX_CHANNELS));
    assign count_inc = count_reg + 1'b1;
    assign trigger   = vector_end || (count_inc >= eff);
    assign rd_addr   = idx_reg[ADDR_W-1:0];

    always_comb
    begin
        if (depth_reg == 7'd0)
        begin
            eff = CNT_W'(1);
        end
        else if ({25'd0, depth_reg} > 32'(MAX_CHANNELS))
        begin
            eff = CNT_W'(MAX_CHANNELS);
        end
        else
        begin
            eff = CNT_W'(depth_reg);
        end
    end

    assign sum_neg = sum_reg[21];
    assign sum_mag = sum_neg ? 22'(-sum_reg) : 22'(sum_reg);
    assign v_sum   = ln_pkg::DIVISOR_W'(var_reg) + ln_pkg::DIVISOR_W'(eps_reg);

    assign d        = 17'(buf_q_reg) - mean_reg;
    assign d_sq     = d * d;
    assign inv_s    = signed'({1'b0, inv_reg});
    assign p1_full  = d * inv_s;
    assign gain_eff   = gain_ok_reg ? gain_q_reg : ln_pkg::GAIN_ONE;
    assign offset_eff = offset_ok_reg ? offset_q_reg : ln_pkg::OFFSET_ZERO;
    assign p_full   = p1_reg * gain_eff;

    // round to nearest, ties away from zero, on the magnitude
    assign p_neg  = p_reg[62];
    assign p_mag  = p_neg ? 63'(-p_reg) : 63'(p_reg);
    assign p_rnd  = (p_mag + (63'd1 << 35)) >> 36;
    assign r_s    = p_neg ? -signed'(p_rnd[27:0]) : signed'(p_rnd[27:0]);
    assign y_full = 30'(r_s) + 30'(offset_eff);

    always_comb
    begin
        if (y_full > 30'sd32767)
        begin
            y_sat = 16'sh7fff;
        end
        else if (y_full < -30'sd32768)
        begin
            y_sat = 16'sh8000;
        end
        else
        begin
            y_sat = y_full[15:0];
        end
    end

    always_comb
    begin
        div_go       = 1'b0;
        div_dividend = '0;
        div_divisor  = '0;
        sqrt_go      = 1'b0;
        unique case (state_reg)
            ln_pkg::ST_MEAN_GO:
            begin
                div_go       = 1'b1;
                div_dividend = ln_pkg::DIVIDEND_W'(sum_mag);
                div_divisor  = ln_pkg::DIVISOR_W'(n_reg);
            end
            ln_pkg::ST_VAR_GO:
            begin
                div_go       = 1'b1;
                div_dividend = ln_pkg::DIVIDEND_W'(sq_reg);
                div_divisor  = ln_pkg::DIVISOR_W'(n_reg);
            end
            ln_pkg::ST_RECIP_GO:
            begin
                div_go       = (v_sum != '0);
                div_dividend = ln_pkg::DIVIDEND_W'(1) << 56;
                div_divisor  = v_sum;
            end
            ln_pkg::ST_SQRT_GO:
            begin
                sqrt_go = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    ln_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .go       (div_go),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

    ln_isqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .go       (sqrt_go),
        .radicand (div_quotient),
        .done     (sqrt_done),
        .root     (sqrt_root)
    );

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        n_next         = n_reg;
        idx_next       = idx_reg;
        pend_a_next    = 1'b0;
        pend_b_next    = 1'b0;
        out_valid_next = 1'b0;
        unique case (state_reg)
            ln_pkg::ST_IDLE:
            begin
                if (accept && is_sample)
                begin
                    if (trigger)
                    begin
                        n_next     = count_inc;
                        count_next = '0;
                        idx_next   = '0;
                        state_next = ln_pkg::ST_SUM;
                    end
                    else
                    begin
                        count_next = count_inc;
                    end
                end
            end
            ln_pkg::ST_SUM:
            begin
                if (idx_reg < n_reg)
                begin
                    idx_next    = idx_reg + 1'b1;
                    pend_a_next = 1'b1;
                end
                else if (!pend_a_reg)
                begin
                    state_next = ln_pkg::ST_MEAN_GO;
                end
            end
            ln_pkg::ST_MEAN_GO:
            begin
                state_next = ln_pkg::ST_MEAN_WAIT;
            end
            ln_pkg::ST_MEAN_WAIT:
            begin
                if (div_done)
                begin
                    idx_next   = '0;
                    state_next = ln_pkg::ST_SQ;
                end
            end
            ln_pkg::ST_SQ:
            begin
                pend_b_next = pend_a_reg;
                if (idx_reg < n_reg)
                begin
                    idx_next    = idx_reg + 1'b1;
                    pend_a_next = 1'b1;
                end
                else if (!pend_a_reg && !pend_b_reg)
                begin
                    state_next = ln_pkg::ST_VAR_GO;
                end
            end
            ln_pkg::ST_VAR_GO:
            begin
                state_next = ln_pkg::ST_VAR_WAIT;
            end
            ln_pkg::ST_VAR_WAIT:
            begin
                if (div_done)
                begin
                    state_next = ln_pkg::ST_RECIP_GO;
                end
            end
            ln_pkg::ST_RECIP_GO:
            begin
                idx_next = '0;
                // zero variance sum skips straight to the saturated reciprocal
                state_next = (v_sum == '0) ? ln_pkg::ST_EMIT_RD : ln_pkg::ST_RECIP_WAIT;
            end
            ln_pkg::ST_RECIP_WAIT:
            begin
                if (div_done)
                begin
                    state_next = ln_pkg::ST_SQRT_GO;
                end
            end
            ln_pkg::ST_SQRT_GO:
            begin
                state_next = ln_pkg::ST_SQRT_WAIT;
            end
            ln_pkg::ST_SQRT_WAIT:
            begin
                if (sqrt_done)
                begin
                    state_next = ln_pkg::ST_EMIT_RD;
                end
            end
            ln_pkg::ST_EMIT_RD:
            begin
                state_next = ln_pkg::ST_EMIT_MUL1;
            end
            ln_pkg::ST_EMIT_MUL1:
            begin
                state_next = ln_pkg::ST_EMIT_MUL2;
            end
            ln_pkg::ST_EMIT_MUL2:
            begin
                state_next = ln_pkg::ST_EMIT_OUT;
            end
            ln_pkg::ST_EMIT_OUT:
            begin
                out_valid_next = 1'b1;
                idx_next       = idx_reg + 1'b1;
                state_next     = (idx_next == n_reg) ? ln_pkg::ST_IDLE : ln_pkg::ST_EMIT_RD;
            end
            default:
            begin
                state_next = ln_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ln_pkg::ST_IDLE;
            count_reg      <= '0;
            n_reg          <= '0;
            idx_reg        <= '0;
            pend_a_reg     <= 1'b0;
            pend_b_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
            depth_reg      <= ln_pkg::DEPTH_RESET;
            eps_reg        <= ln_pkg::EPS_RESET;
            gain_vld_reg   <= '0;
            offset_vld_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            n_reg         <= n_next;
            idx_reg       <= idx_next;
            pend_a_reg    <= pend_a_next;
            pend_b_reg    <= pend_b_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we && cfg_index == ln_pkg::REG_DEPTH)
            begin
                depth_reg <= cfg_data[6:0];
            end
            if (cfg_we && cfg_index == ln_pkg::REG_EPS)
            begin
                eps_reg <= cfg_data;
            end
            if (accept && load_ok && command == ln_pkg::CMD_GAIN)
            begin
                gain_vld_reg[channel_index[ADDR_W-1:0]] <= 1'b1;
            end
            if (accept && load_ok && command == ln_pkg::CMD_OFFSET)
            begin
                offset_vld_reg[channel_index[ADDR_W-1:0]] <= 1'b1;
            end
        end
    end

    // memories: one write port, registered read at the sequencer index
    always_ff @(posedge clk)
    begin
        if (accept && is_sample)
        begin
            buf_mem[count_reg[ADDR_W-1:0]] <= data_value;
        end
        if (accept && load_ok && command == ln_pkg::CMD_GAIN)
        begin
            gain_mem[channel_index[ADDR_W-1:0]] <= data_value;
        end
        if (accept && load_ok && command == ln_pkg::CMD_OFFSET)
        begin
            offset_mem[channel_index[ADDR_W-1:0]] <= data_value;
        end
        buf_q_reg     <= buf_mem[rd_addr];
        gain_q_reg    <= gain_mem[rd_addr];
        offset_q_reg  <= offset_mem[rd_addr];
        gain_ok_reg   <= gain_vld_reg[rd_addr];
        offset_ok_reg <= offset_vld_reg[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ln_pkg::ST_IDLE:
            begin
                sum_reg <= '0;
            end
            ln_pkg::ST_SUM:
            begin
                if (pend_a_reg)
                begin
                    sum_reg <= sum_reg + 22'(buf_q_reg);
                end
            end
            ln_pkg::ST_MEAN_GO:
            begin
                sq_reg <= '0;
            end
            ln_pkg::ST_MEAN_WAIT:
            begin
                if (div_done)
                begin
                    mean_reg <= sum_neg ? -signed'(div_quotient[16:0])
                                        : signed'(div_quotient[16:0]);
                end
            end
            ln_pkg::ST_SQ:
            begin
                if (pend_a_reg)
                begin
                    sqp_reg <= d_sq[31:0];
                end
                if (pend_b_reg)
                begin
                    sq_reg <= sq_reg + 38'(sqp_reg);
                end
            end
            ln_pkg::ST_VAR_WAIT:
            begin
                if (div_done)
                begin
                    var_reg <= div_quotient[32:0];
                end
            end
            ln_pkg::ST_RECIP_GO:
            begin
                inv_reg <= ln_pkg::INV_SAT;
            end
            ln_pkg::ST_SQRT_WAIT:
            begin
                if (sqrt_done)
                begin
                    inv_reg <= sqrt_root;
                end
            end
            ln_pkg::ST_EMIT_MUL1:
            begin
                p1_reg <= p1_full;
            end
            ln_pkg::ST_EMIT_MUL2:
            begin
                p_reg <= p_full;
            end
            ln_pkg::ST_EMIT_OUT:
            begin
                out_value_reg <= y_sat;
                out_last_reg  <= (idx_next == n_reg);
            end
            default:
            begin
            end
        endcase
    end

    assign busy             = (state_reg != ln_pkg::ST_IDLE);
    assign result_valid     = out_valid_reg;
    assign normalized_value = out_value_reg;
    assign result_last      = out_valid_reg && out_last_reg;

    a_result_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(state_reg == ln_pkg::ST_EMIT_OUT))
        else $error("result strobe without an emit step");

    a_last_frees_block: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_last) |-> !busy)
        else $error("block still busy after final result");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg < CNT_W'(MAX_CHANNELS))
        else $error("element count reached the buffer depth");

    a_div_idle_start: assert property (@(posedge clk) disable iff (!rst_n)
        div_go |=> !div_done)
        else $error("divider finished right after a start");

endmodule

// ===== tb/layer_normalization_unit_test.sv =====
`timescale 1ns / 100ps

module layer_normalization_unit_test;

    localparam int CHANNELS = 64;

    typedef struct {
        logic [1:0]         cmd;
        logic [5:0]         chan;
        logic signed [15:0] value;
        logic               last_in;
        logic               typed;
        logic signed [15:0] typed_value;
    } stim_row_t;

    typedef struct {
        logic signed [15:0] value;
        logic               last;
    } norm_result_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic [1:0]         command = ln_pkg::CMD_GAIN;
    logic [5:0]         channel_index = '0;
    logic signed [15:0] data_value = '0;
    logic               vector_end = 1'b0;
    logic               cfg_we = 1'b0;
    logic [1:0]         cfg_index = ln_pkg::REG_DEPTH;
    logic [15:0]        cfg_data = '0;
    logic               result_valid;
    logic signed [15:0] normalized_value;
    logic               result_last;

    // Shadow state of the block
    logic signed [15:0] elem_buf [CHANNELS];
    logic signed [15:0] gain_tbl [CHANNELS];
    logic signed [15:0] offset_tbl [CHANNELS];
    int                 elem_count;
    logic [6:0]         depth_reg;
    logic [15:0]        eps_reg;

    norm_result_t       pending_results[$];
    int                 error_count = 0;
    int                 result_count = 0;
    int                 vector_count = 0;
    int                 item_count = 0;

    layer_normalization_unit u_top (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .command          (command),
        .channel_index    (channel_index),
        .data_value       (data_value),
        .vector_end       (vector_end),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .result_valid     (result_valid),
        .normalized_value (normalized_value),
        .result_last      (result_last)
    );

    always #5 clk = ~clk;

    initial
    begin
        #5ms;
        $display("Timeout with %0d results still expected", pending_results.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        $display("%0t MISMATCH: %s", $realtime, msg);
        error_count++;
    endtask

    function automatic longint unsigned int_sqrt(input longint unsigned x);
        longint unsigned root;
        longint unsigned bit_val;
        root = 0;
        bit_val = 64'd1 << 62;
        while (bit_val > x)
            bit_val >>= 2;
        while (bit_val != 0)
        begin
            if (x >= root + bit_val)
            begin
                x -= root + bit_val;
                root = (root >> 1) + bit_val;
            end
            else
                root >>= 1;
            bit_val >>= 2;
        end
        return root;
    endfunction

    // Normalize the buffered vector and queue one result per element
    function automatic void normalize_vector();
        longint          sum;
        longint          mean;
        longint          diff;
        longint          prod;
        longint          rounded;
        longint          y;
        longint unsigned sq;
        longint unsigned var_q;
        longint unsigned v;
        longint unsigned inv;
        longint unsigned mag;
        norm_result_t    res;
        sum = 0;
        sq = 0;
        for (int i = 0; i < elem_count; i++)
            sum += elem_buf[i];
        mean = sum / elem_count;
        for (int i = 0; i < elem_count; i++)
        begin
            diff = longint'(elem_buf[i]) - mean;
            sq += longint'(diff * diff);
        end
        var_q = sq / elem_count;
        v = var_q + eps_reg;
        inv = (v == 0) ? (64'd1 << 28) : int_sqrt((64'd1 << 56) / v);
        for (int i = 0; i < elem_count; i++)
        begin
            diff = longint'(elem_buf[i]) - mean;
            prod = diff * longint'(inv) * longint'(gain_tbl[i]);
            mag = (prod < 0) ? longint'(-prod) : prod;
            rounded = longint'((mag + (64'd1 << 35)) >> 36);
            y = ((prod < 0) ? -rounded : rounded) + longint'(offset_tbl[i]);
            if (y > 32767)
                y = 32767;
            if (y < -32768)
                y = -32768;
            res.value = y[15:0];
            res.last = (i + 1 == elem_count);
            pending_results.push_back(res);
        end
        elem_count = 0;
        vector_count++;
    endfunction

    function automatic void apply_item(input stim_row_t it);
        int eff;
        case (it.cmd)
            ln_pkg::CMD_GAIN:   gain_tbl[it.chan] = it.value;
            ln_pkg::CMD_OFFSET: offset_tbl[it.chan] = it.value;
            ln_pkg::CMD_SAMPLE:
            begin
                eff = (depth_reg == 0) ? 1 : (depth_reg > CHANNELS) ? CHANNELS : depth_reg;
                if (elem_count >= CHANNELS)
                    elem_count = 0;
                elem_buf[elem_count] = it.value;
                elem_count++;
                if (it.last_in || elem_count >= eff)
                    normalize_vector();
            end
            default: ;
        endcase
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send_item(input stim_row_t it, input int gap);
        norm_result_t res;
        if (gap > 0)
        begin
            start = 1'b0;
            repeat (gap) @(negedge clk);
        end
        start = 1'b1;
        command = it.cmd;
        channel_index = it.chan;
        data_value = it.value;
        vector_end = it.last_in;
        do
            @(posedge clk);
        while (busy);
        apply_item(it);
        item_count++;
        // Replace the predicted single result with the typed-in value
        if (it.typed)
        begin
            res.value = it.typed_value;
            res.last = 1'b1;
            void'(pending_results.pop_back());
            pending_results.push_back(res);
        end
        @(negedge clk);
    endtask

    // Drain the block, then write one register
    task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
        start = 1'b0;
        wait (pending_results.size() == 0);
        @(negedge clk);
        while (busy)
            @(negedge clk);
        repeat (4) @(negedge clk);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = value;
        @(negedge clk);
        cfg_we = 1'b0;
        if (idx == ln_pkg::REG_DEPTH)
            depth_reg = value[6:0];
        else if (idx == ln_pkg::REG_EPS)
            eps_reg = value;
    endtask

    always @(posedge clk)
    begin
        norm_result_t exp_res;
        if (rst_n && result_valid)
        begin
            result_count++;
            if (pending_results.size() == 0)
                report_mismatch($sformatf("unexpected result %0d", normalized_value));
            else
            begin
                exp_res = pending_results.pop_front();
                if (normalized_value !== exp_res.value)
                    report_mismatch($sformatf("normalized_value %0d, expected %0d",
                                              normalized_value, exp_res.value));
                if (result_last !== exp_res.last)
                    report_mismatch($sformatf("result_last %0b, expected %0b",
                                              result_last, exp_res.last));
            end
        end
    end

    function automatic stim_row_t random_item(input bit close_vector, input bit long_vector);
        stim_row_t it;
        int r;
        int vr;
        it.typed = 1'b0;
        it.typed_value = '0;
        it.chan = 6'($urandom_range(0, 63));
        vr = $urandom_range(0, 9);
        if (vr < 4)
            it.value = 16'($urandom);
        else if (vr < 8)
            it.value = 16'($signed($urandom_range(0, 1023)) - 512);
        else
            it.value = vr[0] ? 16'sh7fff : 16'sh8000;
        r = $urandom_range(0, 99);
        if (close_vector)
            r = 50;
        if (r < 8)
            it.cmd = ln_pkg::CMD_GAIN;
        else if (r < 15)
            it.cmd = ln_pkg::CMD_OFFSET;
        else if (r < 18)
            it.cmd = 2'd3;
        else
            it.cmd = ln_pkg::CMD_SAMPLE;
        it.last_in = close_vector ? 1'b1 :
                     long_vector ? ($urandom_range(0, 99) == 0) : ($urandom_range(0, 3) == 0);
        return it;
    endfunction

    stim_row_t directed_rows[] = '{
        '{ln_pkg::CMD_SAMPLE, 6'd5,  16'sh1234, 1'b1, 1'b1, 16'sd0},
        '{ln_pkg::CMD_OFFSET, 6'd0,  16'sh7fff, 1'b0, 1'b0, 16'sd0},
        '{ln_pkg::CMD_SAMPLE, 6'd0,  16'sh8000, 1'b1, 1'b1, 16'sh7fff},
        '{ln_pkg::CMD_OFFSET, 6'd0,  16'sh8000, 1'b0, 1'b0, 16'sd0},
        '{ln_pkg::CMD_SAMPLE, 6'd63, 16'sd5,    1'b1, 1'b1, 16'sh8000},
        '{ln_pkg::CMD_OFFSET, 6'd0,  16'sd0,    1'b0, 1'b0, 16'sd0},
        '{ln_pkg::CMD_GAIN,   6'd0,  16'sh8000, 1'b0, 1'b0, 16'sd0},
        '{ln_pkg::CMD_GAIN,   6'd1,  16'sh7fff, 1'b0, 1'b0, 16'sd0},
        '{ln_pkg::CMD_GAIN,   6'd63, -16'sd1,   1'b0, 1'b0, 16'sd0},
        '{2'd3,               6'd63, 16'shffff, 1'b1, 1'b0, 16'sd0},
        '{ln_pkg::CMD_OFFSET, 6'd2,  16'sh55aa, 1'b0, 1'b0, 16'sd0},
        '{ln_pkg::CMD_SAMPLE, 6'd0,  16'sh7fff, 1'b0, 1'b0, 16'sd0},
        '{ln_pkg::CMD_SAMPLE, 6'd0,  16'sh8000, 1'b0, 1'b0, 16'sd0},
        '{ln_pkg::CMD_SAMPLE, 6'd0,  16'sd0,    1'b1, 1'b0, 16'sd0},
        '{ln_pkg::CMD_SAMPLE, 6'd0,  16'sd100,  1'b0, 1'b0, 16'sd0},
        '{ln_pkg::CMD_GAIN,   6'd1,  16'sd512,  1'b0, 1'b0, 16'sd0},
        '{ln_pkg::CMD_OFFSET, 6'd1,  -16'sd300, 1'b0, 1'b0, 16'sd0},
        '{ln_pkg::CMD_SAMPLE, 6'd0,  -16'sd100, 1'b1, 1'b0, 16'sd0},
        '{ln_pkg::CMD_GAIN,   6'd0,  16'sd256,  1'b0, 1'b0, 16'sd0},
        '{ln_pkg::CMD_SAMPLE, 6'd9,  16'sd77,   1'b0, 1'b0, 16'sd0},
        '{ln_pkg::CMD_SAMPLE, 6'd9,  16'sd77,   1'b1, 1'b0, 16'sd0}
    };

    initial
    begin
        logic [15:0] phase_depth [6] = '{16'd0, 16'd1, 16'd64, 16'd127, 16'd3, 16'd5};
        logic [15:0] phase_eps [6] = '{16'd0, 16'hffff, 16'd0, 16'd1, 16'd300, 16'd40};
        stim_row_t   it;
        bit          long_vec;
        for (int i = 0; i < CHANNELS; i++)
        begin
            elem_buf[i] = '0;
            gain_tbl[i] = ln_pkg::GAIN_ONE;
            offset_tbl[i] = ln_pkg::OFFSET_ZERO;
        end
        elem_count = 0;
        depth_reg = ln_pkg::DEPTH_RESET;
        eps_reg = ln_pkg::EPS_RESET;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
            send_item(directed_rows[i], pick_gap());

        for (int ph = 0; ph < 6; ph++)
        begin
            if (ph == 5)
            begin
                phase_depth[ph] = 16'($urandom_range(0, 127));
                phase_eps[ph] = 16'($urandom);
            end
            write_reg(ln_pkg::REG_DEPTH, phase_depth[ph]);
            write_reg(ln_pkg::REG_EPS, phase_eps[ph]);
            // Out-of-range index must leave both registers alone
            write_reg(2'(2 + ph % 2), 16'($urandom));
            long_vec = (ph == 2 || ph == 3);
            for (int k = 0; k < 36; k++)
            begin
                it = random_item(1'b0, long_vec && k < 30);
                send_item(it, (k % 12 < 4) ? 0 : pick_gap());
            end
            if (elem_count > 0)
            begin
                it = random_item(1'b1, 1'b0);
                send_item(it, pick_gap());
            end
        end

        start = 1'b0;
        wait (pending_results.size() == 0);
        repeat (400) @(posedge clk);
        $display("Sent %0d transactions over 6 register settings; checked %0d results in %0d vectors",
                 item_count, result_count, vector_count);
        if (error_count == 0 && pending_results.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/ln_pkg.sv
rtl/core/ln_divider.sv
rtl/core/ln_isqrt.sv
rtl/core/layer_normalization_unit.sv
tb/layer_normalization_unit_test.sv
